// ----- design/psb_pkg.sv -----
// Package for the prime sieve bitmap block.
// Holds field widths, operation and status codes, and reset constants.
// No dependencies.
`timescale 1ns / 1ps

package psb_pkg;

  // Fixed field widths of the item and register formats.
  localparam int unsigned OP_W     = 1;
  localparam int unsigned NUM_W    = 16;
  localparam int unsigned BOUND_W  = 17;
  localparam int unsigned STATUS_W = 2;

  // Bound value after reset.
  localparam logic [BOUND_W-1:0] BOUND_RESET = 17'd65536;

  // Operation codes carried by an input item.
  localparam logic [OP_W-1:0] OP_BUILD = 1'b0;
  localparam logic [OP_W-1:0] OP_QUERY = 1'b1;

  // Status codes returned with every result item.
  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t STAT_OK           = 2'd0;
  localparam status_t STAT_NOT_BUILT    = 2'd1;
  localparam status_t STAT_OUT_OF_RANGE = 2'd2;

endpackage

// ----- design/psb_if.sv -----
// Handshake interfaces of the prime sieve bitmap block: request, result
// and bound register channels. Depends on psb_pkg.
`timescale 1ns / 1ps

// Request channel: one item is a build or a query.
interface psb_in_if import psb_pkg::*;;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [NUM_W-1:0] query_number;

  modport source (output valid, output operation, output query_number, input ready);
  modport sink (input valid, input operation, input query_number, output ready);
endinterface

// Result channel: one item per request.
interface psb_out_if import psb_pkg::*;;
  logic    valid;
  logic    ready;
  logic    prime_flag;
  status_t status;

  modport source (output valid, output prime_flag, output status, input ready);
  modport sink (input valid, input prime_flag, input status, output ready);
endinterface

// Bound register write channel.
interface psb_cfg_if import psb_pkg::*;;
  logic               valid;
  logic               ready;
  logic [BOUND_W-1:0] upper_bound;

  modport source (output valid, output upper_bound, input ready);
  modport sink (input valid, input upper_bound, output ready);
endinterface

// ----- design/psb_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module psb_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/psb_addcmp.sv -----
// Shared add-and-compare unit of the sieve sequencer: adds two operands and
// tests the sum against the active bound. No dependencies.
`timescale 1ns / 1ps

module psb_addcmp #(
  parameter int unsigned W = 18
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic [W-1:0] bound_i,
  output logic [W-1:0] sum_o,
  output logic         lt_o
);

  // One adder feeding one magnitude compare.
  always_comb begin
    sum_o = a_i + b_i;
    lt_o  = (sum_o < bound_i);
  end

endmodule

// ----- design/prime_sieve_bitmap.sv -----
// Sieve of Eratosthenes over a one-bit-per-number store; top level.
// Depends on psb_pkg, psb_if, psb_ram and psb_addcmp.
`timescale 1ns / 1ps

// A query for a built sieve and an in-range number reads the bit store and
// then loads the result register; a query that answers "not built" or
// "out of range" loads the result register as it is accepted. A build over
// an effective bound B clears every store entry below B, loads the first
// square, tests each base b with b*b < B in a read step and a next step,
// marks each multiple of a prime base p from p*p up to B - 1 as composite,
// and finishes, all paced by the single write port of the bit store and the
// one shared adder. The request channel is not ready during a build or a
// query read, nor while a bound write is offered, nor while a result waits
// untaken. The bound channel is ready only while the sequencer is idle.
// Writing the bound marks the sieve as not built until a build completes.
module prime_sieve_bitmap import psb_pkg::*; #(
  parameter int unsigned MAX_NUMBERS = 65536
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  psb_cfg_if.sink    cfg_i,
  psb_in_if.sink     in_i,
  psb_out_if.source  out_o
);

  localparam int unsigned AW = $clog2(MAX_NUMBERS);
  localparam int unsigned BW = (AW + 1 > BOUND_W) ? AW + 1 : BOUND_W;
  localparam int unsigned CW = BW + 1;
  localparam logic [BW-1:0] BOUND_MAX = BW'(MAX_NUMBERS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QRD,
    ST_CLEAR,
    ST_SQ,
    ST_RD,
    ST_MARK,
    ST_NEXT,
    ST_DONE
  } state_e;

  state_e        state_q;
  logic [BW-1:0] bound_q;
  logic          built_q;
  logic [CW-1:0] ptr_q;
  logic [CW-1:0] sq_q;
  logic [AW-1:0] base_q;
  logic          q_small_q;
  logic          out_valid_q;
  logic          flag_q;
  status_t       status_q;

  logic [BW-1:0] cfg_bound;
  logic [CW-1:0] alu_a;
  logic [CW-1:0] alu_b;
  logic [CW-1:0] alu_sum;
  logic          alu_lt;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic          ram_rdata;
  logic          in_acc;
  logic          res_load;

  // Clamp a written bound to the store size.
  assign cfg_bound = (BW'(cfg_i.upper_bound) > BOUND_MAX) ? BOUND_MAX
                                                          : BW'(cfg_i.upper_bound);

  assign cfg_i.ready = (state_q == ST_IDLE);
  assign in_i.ready  = (state_q == ST_IDLE) && !cfg_i.valid
                    && (!out_valid_q || out_o.ready);
  assign in_acc      = in_i.valid && in_i.ready;

  assign out_o.valid      = out_valid_q;
  assign out_o.prime_flag = flag_q;
  assign out_o.status     = status_q;

  // Operand selection for the shared adder.
  always_comb begin
    case (state_q)
      ST_IDLE: begin
        alu_a = CW'(in_i.query_number);
        alu_b = '0;
      end
      ST_CLEAR: begin
        alu_a = ptr_q;
        alu_b = CW'(1);
      end
      ST_SQ: begin
        alu_a = sq_q;
        alu_b = '0;
      end
      ST_MARK: begin
        alu_a = ptr_q;
        alu_b = CW'(base_q);
      end
      ST_NEXT: begin
        alu_a = sq_q;
        alu_b = CW'({base_q, 1'b1});
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  psb_addcmp #(
    .W (CW)
  ) u_addcmp (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .bound_i (CW'(bound_q)),
    .sum_o   (alu_sum),
    .lt_o    (alu_lt)
  );

  // Store access: clears and marks during a build, base and query reads.
  always_comb begin
    ram_we    = (state_q == ST_CLEAR) || (state_q == ST_MARK);
    ram_waddr = AW'(ptr_q);
    ram_wdata = (state_q == ST_MARK);
    case (state_q)
      ST_IDLE: ram_raddr = AW'(in_i.query_number);
      ST_NEXT: ram_raddr = base_q + AW'(1);
      default: ram_raddr = base_q;
    endcase
  end

  psb_ram #(
    .WIDTH (1),
    .DEPTH (MAX_NUMBERS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // A result register load happens in these cases only.
  assign res_load = (in_acc && in_i.operation == OP_QUERY && !(built_q && alu_lt))
                 || (state_q == ST_QRD) || (state_q == ST_DONE);

  // Sequencer, configuration register and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bound_q     <= (BW'(BOUND_RESET) > BOUND_MAX) ? BOUND_MAX : BW'(BOUND_RESET);
      built_q     <= 1'b0;
      out_valid_q <= 1'b0;
      ptr_q       <= '0;
      sq_q        <= '0;
      base_q      <= '0;
      q_small_q   <= 1'b0;
      flag_q      <= 1'b0;
      status_q    <= STAT_OK;
    end else begin
      // A taken result empties the register unless a new one loads now.
      if (out_o.ready && !res_load) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.valid && cfg_i.ready) begin
        bound_q <= cfg_bound;
        built_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_i.operation == OP_BUILD) begin
              ptr_q   <= '0;
              state_q <= (bound_q == '0) ? ST_DONE : ST_CLEAR;
            end else if (!built_q) begin
              out_valid_q <= 1'b1;
              flag_q      <= 1'b0;
              status_q    <= STAT_NOT_BUILT;
            end else if (!alu_lt) begin
              out_valid_q <= 1'b1;
              flag_q      <= 1'b0;
              status_q    <= STAT_OUT_OF_RANGE;
            end else begin
              q_small_q <= (in_i.query_number < NUM_W'(2));
              state_q   <= ST_QRD;
            end
          end
        end
        ST_QRD: begin
          out_valid_q <= 1'b1;
          flag_q      <= !q_small_q && !ram_rdata;
          status_q    <= STAT_OK;
          state_q     <= ST_IDLE;
        end
        ST_CLEAR: begin
          if (alu_lt) begin
            ptr_q <= alu_sum;
          end else begin
            base_q  <= AW'(2);
            sq_q    <= CW'(4);
            state_q <= ST_SQ;
          end
        end
        ST_SQ: begin
          state_q <= alu_lt ? ST_RD : ST_DONE;
        end
        ST_RD: begin
          if (ram_rdata) begin
            state_q <= ST_NEXT;
          end else begin
            ptr_q   <= sq_q;
            state_q <= ST_MARK;
          end
        end
        ST_MARK: begin
          if (alu_lt) begin
            ptr_q <= alu_sum;
          end else begin
            state_q <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          sq_q    <= alu_sum;
          base_q  <= base_q + AW'(1);
          state_q <= alu_lt ? ST_RD : ST_DONE;
        end
        ST_DONE: begin
          built_q     <= 1'b1;
          out_valid_q <= 1'b1;
          flag_q      <= 1'b0;
          status_q    <= STAT_OK;
          state_q     <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_load && out_valid_q) |-> out_o.ready)
    else $error("result register overwritten while full");

  // The store is written only by the clearing and marking phases of a build.
  a_write_in_build: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_CLEAR || state_q == ST_MARK))
    else $error("store written outside a build");

  // Every store write lies below the active bound.
  a_write_in_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (ptr_q < CW'(bound_q)))
    else $error("store write at or beyond the bound");

  // A build request always leads to the clearing phase or straight to done.
  a_build_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.operation == OP_BUILD)
      |=> (state_q == ST_CLEAR || state_q == ST_DONE))
    else $error("build request did not start a build");
`endif

endmodule
